// ----- hdl/counting_semaphore_table_assert.svh -----
// assertion macros for the semaphore table
`ifndef COUNTING_SEMAPHORE_TABLE_ASSERT_SVH
`define COUNTING_SEMAPHORE_TABLE_ASSERT_SVH
`ifndef ASSERT_OFF
`define CST_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CST_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CST_ASSERT_IMPL(label, clk, rst, prop, msg)
`define CST_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ----- hdl/cst_pkg.sv -----
`timescale 1ns / 1ps
package cst_pkg;
   localparam int CntW = 16;
   localparam int StampW = 16;
   localparam int ProcW = 5;
   localparam int PrioW = 8;

   typedef enum logic [2:0] {
      OP_CREATE = 3'd0, OP_DELETE = 3'd1, OP_SIGNAL = 3'd2, OP_SIGNAL_N = 3'd3,
      OP_RESET = 3'd4, OP_TRY_WAIT = 3'd5, OP_WAIT = 3'd6, OP_READ = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_INVALID = 3'd1, ST_OVERFLOW = 3'd2, ST_NO_WAITER = 3'd3,
      ST_WOULD_BLOCK = 3'd4, ST_BLOCKED = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      WAKE_SIGNAL = 2'd0, WAKE_DELETE = 2'd1, WAKE_RESET = 2'd2
   } wake_type;

   // controller to datapath
   typedef struct packed {
      logic load;        // capture request
      logic scan_start;  // clear best tracker
      logic scan_step;   // examine one slot
      logic release_w;   // free best waiter, emit release item
      logic exec;        // apply command effect
      logic count_inc;   // count += 1 (signal loop)
      logic count_add;   // count += remaining
      logic emit_status; // emit status item
      logic no_waiter;   // status item reports no waiter
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
      logic found;
      logic need_scan;   // command is delete/reset/signal type with scan
      logic loop_more;   // signal_n continue
   } sts_type;
endpackage

// ----- hdl/counting_semaphore_table.sv -----
`timescale 1ns / 1ps
// counting semaphore table
// command channel: drive req_* with start high; the item is taken at an edge
// where busy is low. busy drops in the cycle the status item is on rsp_*.
// result channel: each item is on rsp_* for one cycle with rsp_valid high.
// zero or more release items (rsp_release_valid) then one status item
// (rsp_last high). the receiver cannot stall, so nothing is ever held back.
// sequence: a command with no waiter search goes from accept through the decide
// and status states back to idle, the status item showing as it returns. a
// waiter search walks the MAX_WAITERS slots one per cycle and then picks.
// delete and reset walk once per released process plus one empty walk;
// signal and signal_n walk once per release, plus one when they run out of
// waiters. one command is in flight at a time; the slot walks set how long
// one command takes.
// reset: synchronous, clears semaphore use flags, waiter flags and the
// arrival stamp counter; counts are written at create.
`include "counting_semaphore_table_assert.svh"
module counting_semaphore_table
   import cst_pkg::*;
#(
   parameter int NUM_SEMS = 16,
   parameter int MAX_WAITERS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_operation,
   input  logic [7:0]         req_sem_id,
   input  logic signed [15:0] req_count_arg,
   input  logic [4:0]         req_proc_id,
   input  logic [7:0]         req_proc_prio,
   output logic               rsp_valid,
   output logic [2:0]         rsp_status,
   output logic [3:0]         rsp_result_sem,
   output logic [15:0]        rsp_count_value,
   output logic               rsp_release_valid,
   output logic [4:0]         rsp_released_proc,
   output logic [1:0]         rsp_wake_reason,
   output logic               rsp_last
);
   localparam int SidW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
   localparam int SlotW = $clog2(MAX_WAITERS);

   ctl_type ctl;
   sts_type sts;
   logic [2:0] op_ff;

   // remember the opcode for the signal path choice in the controller
   always_ff @(posedge clock) begin
      if (start && !busy) op_ff <= req_operation;
   end

   cst_control u_ctl (
      .clock, .reset, .start, .busy,
      .is_signal(op_ff == OP_SIGNAL || op_ff == OP_SIGNAL_N),
      .sts, .ctl
   );

   cst_datapath #(
      .NUM_SEMS(NUM_SEMS), .MAX_WAITERS(MAX_WAITERS), .SidW(SidW), .SlotW(SlotW)
   ) u_dp (
      .clock, .reset, .ctl, .sts,
      .req_operation, .req_sem_id, .req_count_arg, .req_proc_id, .req_proc_prio,
      .rsp_valid, .rsp_status, .rsp_result_sem, .rsp_count_value,
      .rsp_release_valid, .rsp_released_proc, .rsp_wake_reason, .rsp_last
   );

   // a release item never closes a command
   `CST_ASSERT_IMPL(a_rel_not_last, clock, reset,
      rsp_valid && rsp_release_valid |-> !rsp_last, "release item marked last")
   // the status item ends the busy period
   `CST_ASSERT_IMPL(a_last_ends, clock, reset,
      rsp_valid && rsp_last |-> !busy, "busy after status item")
   // no result while idle
   `CST_ASSERT_IMPL(a_no_item_idle, clock, reset,
      !busy && !$past(busy) |-> !rsp_valid, "result with no command")
endmodule

// ----- hdl/cst_datapath.sv -----
`timescale 1ns / 1ps
module cst_datapath
   import cst_pkg::*;
#(
   parameter int NUM_SEMS = 16,
   parameter int MAX_WAITERS = 32,
   parameter int SidW = 4,
   parameter int SlotW = 5
) (
   input  logic                clock,
   input  logic                reset,
   input  ctl_type             ctl,
   output sts_type             sts,
   input  logic [2:0]          req_operation,
   input  logic [7:0]          req_sem_id,
   input  logic signed [15:0]  req_count_arg,
   input  logic [4:0]          req_proc_id,
   input  logic [7:0]          req_proc_prio,
   output logic                rsp_valid,
   output logic [2:0]          rsp_status,
   output logic [3:0]          rsp_result_sem,
   output logic [15:0]         rsp_count_value,
   output logic                rsp_release_valid,
   output logic [4:0]          rsp_released_proc,
   output logic [1:0]          rsp_wake_reason,
   output logic                rsp_last
);
   op_type op_ff;
   logic [7:0] sid_ff;
   logic signed [CntW-1:0] arg_ff;
   logic [ProcW-1:0] pid_ff;
   logic [PrioW-1:0] prio_ff;

   logic [CntW-1:0] sem_count_ff [NUM_SEMS];
   logic [NUM_SEMS-1:0] in_use_ff;
   logic [MAX_WAITERS-1:0] wv_ff;
   logic [ProcW-1:0] wproc_ff [MAX_WAITERS];
   logic [PrioW-1:0] wprio_ff [MAX_WAITERS];
   logic [SidW-1:0] wsem_ff [MAX_WAITERS];
   logic [StampW-1:0] wstamp_ff [MAX_WAITERS];
   logic [StampW-1:0] arrival_ff;

   logic signed [CntW:0] cnt_ff;      // working count, 17 bit
   logic signed [CntW:0] rem_ff;      // signal_n remaining
   logic [2:0] st_ff;
   logic [3:0] rs_ff;
   logic [15:0] cv_ff;

   logic [SlotW:0] scan_ff;
   logic found_ff;
   logic [SlotW-1:0] best_ff;
   logic [PrioW-1:0] bprio_ff;
   logic [StampW-1:0] bage_ff;

   logic [SidW-1:0] sidx;
   logic valid_sem;
   logic [SlotW-1:0] si;
   logic [StampW-1:0] age;
   logic hit;
   logic [SidW-1:0] free_id;
   logic free_ok;
   logic [SlotW-1:0] free_slot;
   logic slot_ok;
   logic [2:0] st_next;
   wake_type wake;

   assign sidx = sid_ff[SidW-1:0];
   assign valid_sem = ({24'd0, sid_ff} < NUM_SEMS) && in_use_ff[sidx];
   assign si = scan_ff[SlotW-1:0];
   assign age = arrival_ff - wstamp_ff[si];
   assign hit = wv_ff[si] && (wsem_ff[si] == sidx) &&
      (!found_ff || wprio_ff[si] > bprio_ff ||
       (wprio_ff[si] == bprio_ff && age > bage_ff));

   always_comb begin
      free_id = '0;
      free_ok = 1'b0;
      for (int i = NUM_SEMS - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            free_id = SidW'(i);
            free_ok = 1'b1;
         end
      end
      free_slot = '0;
      slot_ok = 1'b0;
      for (int i = MAX_WAITERS - 1; i >= 0; i--) begin
         if (!wv_ff[i]) begin
            free_slot = SlotW'(i);
            slot_ok = 1'b1;
         end
      end
   end

   always_comb begin
      unique case (op_ff)
         OP_DELETE: wake = WAKE_DELETE;
         OP_RESET:  wake = WAKE_RESET;
         default:   wake = WAKE_SIGNAL;
      endcase
   end

   // status flags for the controller
   always_comb begin
      sts.scan_done = (scan_ff == (SlotW+1)'(MAX_WAITERS));
      sts.found = found_ff;
      sts.need_scan = 1'b0;
      if (valid_sem) begin
         unique case (op_ff)
            OP_DELETE: sts.need_scan = 1'b1;
            OP_RESET: sts.need_scan = (arg_ff >= 0);
            OP_SIGNAL: sts.need_scan = (cnt_ff + 17'sd1 <= 17'sd32767) &&
               (cnt_ff + 17'sd1 <= 17'sd0);
            OP_SIGNAL_N: sts.need_scan = (arg_ff > 0) &&
               ($signed({cnt_ff[CntW], cnt_ff}) +
                $signed({{2{arg_ff[CntW-1]}}, arg_ff}) <= 18'sd32767) &&
               (cnt_ff + 17'sd1 <= 17'sd0);
            default: sts.need_scan = 1'b0;
         endcase
      end
      // another signal_n round: more left and the next one still needs a waiter
      sts.loop_more = (op_ff == OP_SIGNAL_N) && (rem_ff > 17'sd1) &&
         (cnt_ff + 17'sd2 <= 17'sd0);
   end

   always_comb begin
      st_next = ST_OK;
      if (op_ff != OP_CREATE && !valid_sem) st_next = ST_INVALID;
      else begin
         unique case (op_ff)
            OP_CREATE: if (!free_ok || arg_ff < 0) st_next = ST_INVALID;
            OP_SIGNAL: if (cnt_ff + 17'sd1 > 17'sd32767) st_next = ST_OVERFLOW;
            OP_SIGNAL_N: begin
               if (arg_ff < 0) st_next = ST_INVALID;
               else if ($signed({cnt_ff[CntW], cnt_ff}) +
                  $signed({{2{arg_ff[CntW-1]}}, arg_ff}) > 18'sd32767)
                  st_next = ST_OVERFLOW;
            end
            OP_RESET: if (arg_ff < 0) st_next = ST_INVALID;
            OP_TRY_WAIT: begin
               if (cnt_ff == -17'sd32768) st_next = ST_OVERFLOW;
               else if (cnt_ff <= 0) st_next = ST_WOULD_BLOCK;
            end
            OP_WAIT: begin
               if (cnt_ff == -17'sd32768) st_next = ST_OVERFLOW;
               else if (cnt_ff <= 0) st_next = slot_ok ? ST_BLOCKED : ST_INVALID;
            end
            default: st_next = ST_OK;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= '0;
         wv_ff <= '0;
         arrival_ff <= '0;
         rsp_valid <= 1'b0;
         found_ff <= 1'b0;
         scan_ff <= '0;
      end else begin
         rsp_valid <= ctl.release_w || ctl.emit_status;
         if (ctl.load) begin
            op_ff <= op_type'(req_operation);
            sid_ff <= req_sem_id;
            arg_ff <= req_count_arg;
            pid_ff <= req_proc_id;
            prio_ff <= req_proc_prio;
            st_ff <= ST_OK;
            rs_ff <= '0;
            cv_ff <= '0;
            // a plain signal is a single round
            rem_ff <= (req_operation == OP_SIGNAL) ? 17'sd1 :
               {req_count_arg[CntW-1], req_count_arg};
            cnt_ff <= ({24'd0, req_sem_id} < NUM_SEMS) ?
               {sem_count_ff[req_sem_id[SidW-1:0]][CntW-1],
                sem_count_ff[req_sem_id[SidW-1:0]]} : '0;
         end
         if (ctl.scan_start) begin
            scan_ff <= '0;
            found_ff <= 1'b0;
         end
         if (ctl.scan_step) begin
            scan_ff <= scan_ff + 1'b1;
            if (hit) begin
               found_ff <= 1'b1;
               best_ff <= si;
               bprio_ff <= wprio_ff[si];
               bage_ff <= age;
            end
         end
         if (ctl.count_inc) begin
            cnt_ff <= cnt_ff + 17'sd1;
            rem_ff <= rem_ff - 17'sd1;
            sem_count_ff[sidx] <= CntW'(cnt_ff + 17'sd1);
         end
         if (ctl.count_add) begin
            // count went positive or nothing is left: add the rest at once
            cnt_ff <= cnt_ff + rem_ff;
            sem_count_ff[sidx] <= CntW'(cnt_ff + rem_ff);
         end
         if (ctl.release_w) begin
            wv_ff[best_ff] <= 1'b0;
            rsp_status <= ST_OK;
            rsp_result_sem <= '0;
            rsp_count_value <= '0;
            rsp_release_valid <= 1'b1;
            rsp_released_proc <= wproc_ff[best_ff];
            rsp_wake_reason <= wake;
            rsp_last <= 1'b0;
         end
         if (ctl.exec) begin
            st_ff <= st_next;
            if (st_next == ST_OK || st_next == ST_BLOCKED) begin
               unique case (op_ff)
                  OP_CREATE: begin
                     in_use_ff[free_id] <= 1'b1;
                     sem_count_ff[free_id] <= arg_ff;
                     rs_ff <= 4'(free_id);
                  end
                  OP_DELETE: in_use_ff[sidx] <= 1'b0;
                  OP_RESET: sem_count_ff[sidx] <= arg_ff;
                  OP_TRY_WAIT: sem_count_ff[sidx] <= CntW'(cnt_ff - 17'sd1);
                  OP_WAIT: begin
                     sem_count_ff[sidx] <= CntW'(cnt_ff - 17'sd1);
                     if (st_next == ST_BLOCKED) begin
                        wv_ff[free_slot] <= 1'b1;
                        wproc_ff[free_slot] <= pid_ff;
                        wprio_ff[free_slot] <= prio_ff;
                        wsem_ff[free_slot] <= sidx;
                        wstamp_ff[free_slot] <= arrival_ff;
                        arrival_ff <= arrival_ff + 1'b1;
                     end
                  end
                  OP_READ: cv_ff <= sem_count_ff[sidx];
                  OP_SIGNAL: begin
                     if (cnt_ff + 17'sd1 > 17'sd0)
                        sem_count_ff[sidx] <= CntW'(cnt_ff + 17'sd1);
                  end
                  OP_SIGNAL_N: begin
                     if (arg_ff > 0 && cnt_ff + 17'sd1 > 17'sd0)
                        sem_count_ff[sidx] <= CntW'(cnt_ff + rem_ff);
                  end
                  default: ;
               endcase
            end
         end
         if (ctl.emit_status) begin
            rsp_status <= ctl.no_waiter ? ST_NO_WAITER : st_ff;
            rsp_result_sem <= rs_ff;
            rsp_count_value <= cv_ff;
            rsp_release_valid <= 1'b0;
            rsp_released_proc <= '0;
            rsp_wake_reason <= WAKE_SIGNAL;
            rsp_last <= 1'b1;
         end
      end
   end
endmodule

// ----- hdl/cst_control.sv -----
`timescale 1ns / 1ps
module cst_control
   import cst_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  logic    is_signal,
   input  sts_type sts,
   output ctl_type ctl
);
   typedef enum logic [5:0] {
      S_IDLE = 6'b000001, S_DECIDE = 6'b000010, S_SCAN = 6'b000100,
      S_PICK = 6'b001000, S_STATUS = 6'b010000, S_NOWAIT = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      ctl = '0;
      unique case (state_ff)
         S_IDLE: begin
            ctl.load = start;
            if (start) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            ctl.scan_start = 1'b1;
            if (sts.need_scan) state_in = S_SCAN;
            else begin
               ctl.exec = 1'b1;
               state_in = S_STATUS;
            end
         end
         S_SCAN: begin
            ctl.scan_step = !sts.scan_done;
            if (sts.scan_done) state_in = S_PICK;
         end
         S_PICK: begin
            if (!sts.found) begin
               if (is_signal) begin
                  // the signal still counts even with nobody to wake
                  ctl.count_inc = 1'b1;
                  state_in = S_NOWAIT;
               end else begin
                  ctl.exec = 1'b1;
                  state_in = S_STATUS;
               end
            end else begin
               ctl.release_w = 1'b1;
               if (!is_signal) begin
                  ctl.scan_start = 1'b1;
                  state_in = S_SCAN;
               end else begin
                  ctl.count_inc = 1'b1;
                  if (sts.loop_more) begin
                     ctl.scan_start = 1'b1;
                     state_in = S_SCAN;
                  end else begin
                     state_in = S_NOWAIT;
                  end
               end
            end
         end
         S_NOWAIT: begin
            // signal path ends here: no waiter, or rest applied
            ctl.emit_status = 1'b1;
            ctl.no_waiter = !sts.found;
            ctl.count_add = sts.found;
            state_in = S_IDLE;
         end
         S_STATUS: begin
            ctl.emit_status = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end
endmodule
